// ===== hdl/pbl_pkg.sv =====
// shared codes and types for the positional byte list
`timescale 1ns / 1ps
package pbl_pkg;

    localparam int ModeW   = 3;
    localparam int PosW    = 5;
    localparam int ByteW   = 8;
    localparam int StatusW = 2;
    localparam int LenW    = 5;

    localparam logic [ModeW-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [ModeW-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [ModeW-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [ModeW-1:0] MODE_REM_FRONT = 3'd3;
    localparam logic [ModeW-1:0] MODE_REM_BACK  = 3'd4;
    localparam logic [ModeW-1:0] MODE_REM_POS   = 3'd5;

    localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatusW-1:0] STAT_FULL  = 2'd1;
    localparam logic [StatusW-1:0] STAT_EMPTY = 2'd2;
    localparam logic [StatusW-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic ins;
        logic rem;
    } pbl_op_t;

endpackage

// ===== hdl/positional_byte_list_unit.sv =====
// top level of the positional byte list: control and chain of cells
`timescale 1ns / 1ps
// result of an accepted request is valid in the output register in the cycle after accept
// throughput: one request per cycle unless in_stall holds it; every cell shifts in the same edge
// in_stall is high only while a result waits and out_stall holds it
// reset clears the element count and the output valid; the result payload and cell
// contents are not reset, and cells hold no meaning until written by an insert
module positional_byte_list_unit import pbl_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ModeW-1:0]   mode,
    input  logic [PosW-1:0]    position,
    input  logic [ByteW-1:0]   data_in,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ByteW-1:0]   data_out,
    output logic [StatusW-1:0] status,
    output logic [LenW-1:0]    length
);

    // count must hold CAPACITY itself
    localparam int CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;
    logic               out_valid_reg;
    logic [ByteW-1:0]   data_out_reg;
    logic [StatusW-1:0] status_reg;
    logic [LenW-1:0]    length_reg;

    logic               accept;
    pbl_op_t            op;
    logic [CntW-1:0]    slot;
    logic [StatusW-1:0] req_status;

    // chain wiring: cell data and the removed-byte collection path
    logic [ByteW-1:0]   cell_data [CAPACITY];
    logic [ByteW-1:0]   tap       [CAPACITY+1];

    // a new request is taken unless a finished result is held back
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    pbl_ctrl #(
        .Capacity (CAPACITY),
        .CntW     (CntW)
    ) u_ctrl (
        .mode       (mode),
        .position   (position),
        .count      (count_reg),
        .op         (op),
        .slot       (slot),
        .status     (req_status),
        .count_next (count_next)
    );

    assign tap[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ByteW-1:0] left_d;
            logic [ByteW-1:0] right_d;

            // front cell has no left neighbor, back cell no right neighbor
            if (gi == 0)
            begin : g_front
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_back
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[gi+1];
            end

            pbl_cell #(
                .Idx   (gi),
                .SlotW (CntW)
            ) u_cell (
                .clk     (clk),
                .en      (accept),
                .op      (op),
                .slot    (slot),
                .data_in (data_in),
                .left    (left_d),
                .right   (right_d),
                .tap_in  (tap[gi]),
                .data    (cell_data[gi]),
                .tap_out (tap[gi+1])
            );
        end
    endgenerate

    // length and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg <= tap[CAPACITY];
            status_reg   <= req_status;
            length_reg   <= LenW'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign length    = length_reg;

endmodule

// ===== hdl/pbl_cell.sv =====
// one storage cell of the list chain
`timescale 1ns / 1ps
module pbl_cell import pbl_pkg::*; #(
    parameter int Idx   = 0,
    parameter int SlotW = 5
) (
    input  logic             clk,
    input  logic             en,
    input  pbl_op_t          op,
    input  logic [SlotW-1:0] slot,
    input  logic [ByteW-1:0] data_in,
    input  logic [ByteW-1:0] left,
    input  logic [ByteW-1:0] right,
    input  logic [ByteW-1:0] tap_in,
    output logic [ByteW-1:0] data,
    output logic [ByteW-1:0] tap_out
);

    localparam logic [SlotW-1:0] MyIdx = SlotW'(Idx);

    logic [ByteW-1:0] data_reg;
    logic [ByteW-1:0] data_next;
    logic             hit;
    logic             above;

    assign hit   = (slot == MyIdx);
    assign above = (MyIdx > slot);

    always_comb
    begin
        data_next = data_reg;
        if (op.ins)
        begin
            if (above)
                data_next = left;
            else if (hit)
                data_next = data_in;
        end
        else if (op.rem)
        begin
            if (above || hit)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign data    = data_reg;
    // removed byte travels down the chain
    assign tap_out = tap_in | ((op.rem && hit) ? data_reg : '0);

endmodule

// ===== hdl/pbl_ctrl.sv =====
// request decode, range checks and length update
`timescale 1ns / 1ps
module pbl_ctrl import pbl_pkg::*; #(
    parameter int Capacity = 16,
    parameter int CntW     = 5
) (
    input  logic [ModeW-1:0]   mode,
    input  logic [PosW-1:0]    position,
    input  logic [CntW-1:0]    count,
    output pbl_op_t            op,
    output logic [CntW-1:0]    slot,
    output logic [StatusW-1:0] status,
    output logic [CntW-1:0]    count_next
);

    localparam int CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
    localparam logic [CntW-1:0] Full = CntW'(Capacity);

    logic [CmpW-1:0] pos_w;
    logic [CmpW-1:0] cnt_w;
    logic [CmpW-1:0] pos_m1;

    assign pos_w  = CmpW'(position);
    assign cnt_w  = CmpW'(count);
    assign pos_m1 = pos_w - CmpW'(1);

    always_comb
    begin
        op         = '0;
        slot       = '0;
        status     = STAT_OK;
        count_next = count;
        case (mode) inside
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
            begin
                if (count >= Full)
                    status = STAT_FULL;
                else if (mode == MODE_INS_POS &&
                         (pos_w == '0 || pos_w > cnt_w + CmpW'(1)))
                    status = STAT_RANGE;
                else
                begin
                    op.ins     = 1'b1;
                    count_next = count + CntW'(1);
                    if (mode == MODE_INS_BACK)
                        slot = count;
                    else if (mode == MODE_INS_POS)
                        slot = CntW'(pos_m1);
                end
            end
            MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_POS:
            begin
                if (count == '0)
                    status = STAT_EMPTY;
                else if (mode == MODE_REM_POS && (pos_w == '0 || pos_w > cnt_w))
                    status = STAT_RANGE;
                else
                begin
                    op.rem     = 1'b1;
                    count_next = count - CntW'(1);
                    if (mode == MODE_REM_BACK)
                        slot = count - CntW'(1);
                    else if (mode == MODE_REM_POS)
                        slot = CntW'(pos_m1);
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_positional_byte_list_unit.sv =====
// self-checking testbench for the positional byte list unit
`timescale 1ns / 1ps
module tb_positional_byte_list_unit;
    import pbl_pkg::*;

    localparam int ListDepth = 16;
    localparam int TimeoutNs = 10_000_000;

    // mode codes the block leaves unused; they must come back as a plain ok
    localparam logic [ModeW-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [ModeW-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ByteW-1:0]   data;
        logic [StatusW-1:0] status;
        logic [LenW-1:0]    length;
    } list_result_t;

    // how the result side applies back-pressure
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } stall_style_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [ModeW-1:0]   mode      = MODE_INS_FRONT;
    logic [PosW-1:0]    position  = '0;
    logic [ByteW-1:0]   data_in   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [ByteW-1:0]   data_out;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    length;

    // predicted list contents, front at index 0
    logic [ByteW-1:0] list_bytes[$];
    // results predicted for accepted requests, oldest first
    list_result_t     pending_results[$];
    list_result_t     oldest;
    int               error_count = 0;

    // sender burst state, owned by the stimulus process
    bit               sender_gaps = 1'b0;
    int               burst_left  = 0;

    // receiver controls, written only by the stimulus process
    stall_style_t     stall_style = STALL_NONE;
    int               hold_len    = 0;
    int               hold_id     = 0;

    positional_byte_list_unit #(
        .CAPACITY(ListDepth)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .position (position),
        .data_in  (data_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data_out (data_out),
        .status   (status),
        .length   (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // apply one request to the predicted list and return the result it must give;
    // full and empty are judged before the position
    function automatic list_result_t list_apply(input logic [ModeW-1:0] m,
                                                input logic [PosW-1:0] p,
                                                input logic [ByteW-1:0] d);
        list_result_t r;
        r.data   = '0;
        r.status = STAT_OK;
        case (m)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
            begin
                if (list_bytes.size() >= ListDepth)
                    r.status = STAT_FULL;
                else if (m == MODE_INS_FRONT)
                    list_bytes.push_front(d);
                else if (m == MODE_INS_BACK)
                    list_bytes.push_back(d);
                else if (p < 1 || p > list_bytes.size() + 1)
                    r.status = STAT_RANGE;
                else
                    list_bytes.insert(p - 1, d);
            end
            MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_POS:
            begin
                if (list_bytes.size() == 0)
                    r.status = STAT_EMPTY;
                else if (m == MODE_REM_FRONT)
                    r.data = list_bytes.pop_front();
                else if (m == MODE_REM_BACK)
                    r.data = list_bytes.pop_back();
                else if (p < 1 || p > list_bytes.size())
                    r.status = STAT_RANGE;
                else
                begin
                    r.data = list_bytes[p - 1];
                    list_bytes.delete(p - 1);
                end
            end
            default:
            begin
                // spare modes leave the list alone
            end
        endcase
        r.length = LenW'(list_bytes.size());
        return r;
    endfunction

    // offer one request and hold it until taken; valid stays high into the next request
    // unless gaps are on and a burst ends, then valid drops for a gap before the next one
    task automatic send_request(input logic [ModeW-1:0] m, input logic [PosW-1:0] p,
                                input logic [ByteW-1:0] d);
        int gap;
        in_valid <= 1'b1;
        mode     <= m;
        position <= p;
        data_in  <= d;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(list_apply(m, p, d));
        if (sender_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    // every remove mode on an empty list, spare modes, bad insert positions and one good one
    task automatic test_empty_list();
        send_request(MODE_REM_FRONT, 5'd1, 8'h3c);
        send_request(MODE_REM_BACK, 5'd1, 8'hc3);
        // empty wins over a bad position
        send_request(MODE_REM_POS, 5'd0, 8'h00);
        send_request(MODE_SPARE_LO, 5'd31, 8'hff);
        send_request(MODE_SPARE_HI, 5'd16, 8'h81);
        send_request(MODE_INS_POS, 5'd0, 8'h12);
        send_request(MODE_INS_POS, 5'd2, 8'h34);
        send_request(MODE_INS_POS, 5'd1, 8'h56);
    endtask

    // grow to capacity with byte extremes, then inserts into a full list
    task automatic test_fill_to_capacity();
        logic [ModeW-1:0] m;
        send_request(MODE_INS_FRONT, 5'd0, 8'h00);
        send_request(MODE_INS_BACK, 5'd31, 8'hff);
        send_request(MODE_INS_POS, 5'd2, 8'ha5);
        // position one past the tail appends
        send_request(MODE_INS_POS, PosW'(list_bytes.size() + 1), 8'h5a);
        while (list_bytes.size() < ListDepth)
        begin
            case ($urandom_range(0, 2))
                0:       m = MODE_INS_FRONT;
                1:       m = MODE_INS_BACK;
                default: m = MODE_INS_POS;
            endcase
            send_request(m, PosW'($urandom_range(1, list_bytes.size() + 1)),
                         ByteW'($urandom_range(0, 255)));
        end
        send_request(MODE_INS_BACK, 5'd1, 8'h11);
        // full wins over a bad position
        send_request(MODE_INS_POS, 5'd31, 8'h22);
    endtask

    // positions at and just past the ends of a list that starts full
    task automatic test_position_limits();
        send_request(MODE_REM_POS, 5'd0, 8'h77);
        send_request(MODE_REM_POS, 5'd17, 8'h88);
        send_request(MODE_REM_POS, 5'd16, 8'h99);
        send_request(MODE_INS_POS, 5'd17, 8'haa);
    endtask

    // random traffic steered toward a target length that wanders over the whole
    // range, so the list keeps passing through empty and full; a few requests
    // are pure noise over every mode and position code
    task automatic test_random_traffic(input int count);
        int               target;
        int               fill;
        int               roll;
        bit               grow;
        logic [ModeW-1:0] m;
        logic [PosW-1:0]  p;
        target = $urandom_range(0, ListDepth);
        for (int i = 0; i < count; i++)
        begin
            fill = list_bytes.size();
            if ($urandom_range(0, 29) == 0)
                target = $urandom_range(0, ListDepth);
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                m = ModeW'($urandom_range(0, 7));
                p = PosW'($urandom());
            end
            else
            begin
                grow = (fill < target) ? (roll < 80) : (roll < 25);
                case ($urandom_range(0, 2))
                    0:       m = grow ? MODE_INS_FRONT : MODE_REM_FRONT;
                    1:       m = grow ? MODE_INS_BACK : MODE_REM_BACK;
                    default: m = grow ? MODE_INS_POS : MODE_REM_POS;
                endcase
                if (grow)
                    p = PosW'($urandom_range(1, fill + 1));
                else
                    p = PosW'($urandom_range(1, (fill == 0) ? 1 : fill));
            end
            send_request(m, p, ByteW'($urandom_range(0, 255)));
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the result register fills and the input side stalls
    task automatic test_backpressure();
        bit saved_gaps;
        saved_gaps  = sender_gaps;
        sender_gaps = 1'b0;
        hold_len    = 80;
        hold_id++;
        for (int i = 0; i < 12; i++)
            send_request(MODE_INS_BACK, 5'd1, ByteW'($urandom_range(0, 255)));
        for (int i = 0; i < 12; i++)
            send_request(MODE_REM_FRONT, 5'd1, ByteW'($urandom_range(0, 255)));
        sender_gaps = saved_gaps;
    endtask

    // result side: a fresh hold request wins, otherwise the current style
    initial
    begin : receiver
        int pattern_pos;
        int hold_left;
        int hold_seen;
        pattern_pos = 0;
        hold_left   = 0;
        hold_seen   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_id != hold_seen)
            begin
                hold_seen = hold_id;
                hold_left = hold_len;
            end
            pattern_pos++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_style)
                    STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
                    STALL_PATTERN: out_stall <= ((pattern_pos % 7) < 3);
                    default:       out_stall <= 1'b0;
                endcase
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result data_out %0h status %0d length %0d",
                         $time, data_out, status, length);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (data_out !== oldest.data)
                begin
                    error_count++;
                    $display("%0t: data_out expected %0h, got %0h",
                             $time, oldest.data, data_out);
                end
                if (status !== oldest.status)
                begin
                    error_count++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest.status, status);
                end
                if (length !== oldest.length)
                begin
                    error_count++;
                    $display("%0t: length expected %0d, got %0d",
                             $time, oldest.length, length);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_to_capacity();
        test_position_limits();
        wait_drained();

        // a stretch with no idling on either side
        test_random_traffic(250);
        wait_drained();

        sender_gaps = 1'b1;
        stall_style = STALL_RANDOM;
        test_random_traffic(250);
        test_backpressure();
        wait_drained();

        sender_gaps = 1'b0;
        stall_style = STALL_PATTERN;
        test_random_traffic(250);

        sender_gaps = 1'b1;
        test_random_traffic(250);
        wait_drained();

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("tb_positional_byte_list_unit: done, clean");
        else
            $display("tb_positional_byte_list_unit: done, errors");
        $finish;
    end

    initial
    begin
        #(TimeoutNs);
        $display("tb_positional_byte_list_unit: done, errors");
        $finish;
    end

endmodule

// ===== positional_byte_list_unit.f =====
hdl/pbl_pkg.sv
hdl/pbl_cell.sv
hdl/pbl_ctrl.sv
hdl/positional_byte_list_unit.sv
tb/sv/tb_positional_byte_list_unit.sv
